// ----- hw/rtl/kfwrl_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// kfwrl_pkg
// Shared types, sizes and codes of the keyed fixed-window rate limiter.
// ----------------------------------------------------------------------------
package kfwrl_pkg;

  localparam int TABLE_ENTRIES = 16;
  localparam int KEY_W         = 16;
  localparam int LIMIT_W       = 8;
  localparam int TIME_W        = 32;
  localparam int IDX_W         = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int USED_W        = $clog2(TABLE_ENTRIES + 1);

  localparam logic [TIME_W-1:0] WINDOW_RESET = TIME_W'(100000);

  localparam logic [1:0] OUT_PASS     = 2'd0;
  localparam logic [1:0] OUT_SUPPRESS = 2'd1;
  localparam logic [1:0] OUT_FULL     = 2'd2;

  localparam logic [1:0] OP_KEY_EQ = 2'd0;
  localparam logic [1:0] OP_AGED   = 2'd1;
  localparam logic [1:0] OP_BELOW  = 2'd2;

  typedef struct packed {
    logic [KEY_W-1:0]   key;
    logic [LIMIT_W-1:0] count;
    logic [TIME_W-1:0]  start;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef struct packed {
    logic [1:0]        op;
    logic [TIME_W-1:0] a;
    logic [TIME_W-1:0] b;
    logic [TIME_W-1:0] c;
  } alu_req_t;

endpackage
`default_nettype wire

// ----- hw/rtl/kfwrl_ram.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// kfwrl_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module kfwrl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                                     clk,
  input  wire logic                                     we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                         wdata,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ----- hw/rtl/kfwrl_alu.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// kfwrl_alu
// Shared compare unit: key match, window age test and count-below-limit test.
// ----------------------------------------------------------------------------
module kfwrl_alu (
  input  wire kfwrl_pkg::alu_req_t req,
  output logic                     hit
);
  import kfwrl_pkg::*;

  logic [TIME_W-1:0] diff;

  assign diff = req.a - req.b;

  always_comb begin
    unique case (req.op)
      OP_KEY_EQ: hit = (req.a == req.b);
      OP_AGED:   hit = (diff > req.c);
      OP_BELOW:  hit = (req.a < req.b);
      default:   hit = 1'b0;
    endcase
  end

endmodule
`default_nettype wire

// ----- hw/rtl/kfwrl_seq.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// kfwrl_seq
// Sequencer: scans the entry table, ages the window, updates the count and
// holds the result register.
// ----------------------------------------------------------------------------
module kfwrl_seq (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic [kfwrl_pkg::KEY_W-1:0]    key_id,
  input  wire logic [kfwrl_pkg::LIMIT_W-1:0]  limit,
  input  wire logic [kfwrl_pkg::TIME_W-1:0]   now,
  input  wire logic [kfwrl_pkg::TIME_W-1:0]   window_ticks,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic                                pass,
  output logic [1:0]                          outcome,
  output logic                                ram_we,
  output logic [kfwrl_pkg::IDX_W-1:0]         ram_waddr,
  output kfwrl_pkg::entry_t                   ram_wdata,
  output logic [kfwrl_pkg::IDX_W-1:0]         ram_raddr,
  input  wire kfwrl_pkg::entry_t              ram_rdata
);
  import kfwrl_pkg::*;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_SCAN  = 3'd1;
  localparam logic [2:0] ST_ALLOC = 3'd2;
  localparam logic [2:0] ST_AGE   = 3'd3;
  localparam logic [2:0] ST_COUNT = 3'd4;
  localparam logic [2:0] ST_DONE  = 3'd5;

  logic [2:0]         state, state_next;
  logic [IDX_W-1:0]   idx, idx_next;
  logic [USED_W-1:0]  used, used_next;
  logic [KEY_W-1:0]   key_r, key_next;
  logic [LIMIT_W-1:0] lim_r, lim_next;
  logic [TIME_W-1:0]  now_r, now_next;
  logic [LIMIT_W-1:0] ent_count, ent_count_next;
  logic [TIME_W-1:0]  ent_start, ent_start_next;
  logic               res_pass, res_pass_next;
  logic [1:0]         res_outcome, res_outcome_next;
  logic               out_valid_next;
  logic               pass_next;
  logic [1:0]         outcome_next;
  alu_req_t           req;
  logic               hit;

  kfwrl_alu u_alu (
    .req (req),
    .hit (hit)
  );

  assign in_ready  = (state == ST_IDLE);
  assign ram_waddr = idx;
  assign ram_raddr = idx_next;

  always_comb begin
    state_next       = state;
    idx_next         = idx;
    used_next        = used;
    key_next         = key_r;
    lim_next         = lim_r;
    now_next         = now_r;
    ent_count_next   = ent_count;
    ent_start_next   = ent_start;
    res_pass_next    = res_pass;
    res_outcome_next = res_outcome;
    out_valid_next   = out_valid && !out_ready;
    pass_next        = pass;
    outcome_next     = outcome;
    ram_we           = 1'b0;
    ram_wdata.key    = key_r;
    ram_wdata.count  = ent_count;
    ram_wdata.start  = ent_start;
    req.op           = OP_KEY_EQ;
    req.a            = TIME_W'(key_r);
    req.b            = TIME_W'(ram_rdata.key);
    req.c            = '0;

    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          key_next   = key_id;
          lim_next   = limit;
          now_next   = now;
          idx_next   = '0;
          state_next = (used == '0) ? ST_ALLOC : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (hit) begin
          ent_count_next = ram_rdata.count;
          ent_start_next = ram_rdata.start;
          state_next     = ST_AGE;
        end else if (USED_W'(idx) + USED_W'(1) == used) begin
          if (used == USED_W'(TABLE_ENTRIES)) begin
            res_pass_next    = 1'b1;
            res_outcome_next = OUT_FULL;
            state_next       = ST_DONE;
          end else begin
            idx_next   = used[IDX_W-1:0];
            state_next = ST_ALLOC;
          end
        end else begin
          idx_next = idx + IDX_W'(1);
        end
      end
      ST_ALLOC: begin
        used_next      = used + USED_W'(1);
        ent_count_next = '0;
        ent_start_next = now_r;
        state_next     = ST_COUNT;
      end
      ST_AGE: begin
        req.op = OP_AGED;
        req.a  = now_r;
        req.b  = ent_start;
        req.c  = window_ticks;
        if (hit) begin
          ent_count_next = '0;
          ent_start_next = now_r;
        end
        state_next = ST_COUNT;
      end
      ST_COUNT: begin
        req.op          = OP_BELOW;
        req.a           = TIME_W'(ent_count);
        req.b           = TIME_W'(lim_r);
        ram_we          = 1'b1;
        ram_wdata.count = hit ? ent_count + LIMIT_W'(1) : ent_count;
        res_pass_next   = hit;
        res_outcome_next = hit ? OUT_PASS : OUT_SUPPRESS;
        state_next      = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid || out_ready) begin
          out_valid_next = 1'b1;
          pass_next      = res_pass;
          outcome_next   = res_outcome;
          state_next     = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      used      <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      used      <= used_next;
      out_valid <= out_valid_next;
    end
    idx         <= idx_next;
    key_r       <= key_next;
    lim_r       <= lim_next;
    now_r       <= now_next;
    ent_count   <= ent_count_next;
    ent_start   <= ent_start_next;
    res_pass    <= res_pass_next;
    res_outcome <= res_outcome_next;
    pass        <= pass_next;
    outcome     <= outcome_next;
  end

endmodule
`default_nettype wire

// ----- hw/rtl/keyed_fixed_window_rate_limiter_top.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// keyed_fixed_window_rate_limiter_top
// Per-key fixed-window rate limiter with a 16-entry key table.
// Path: an empty table goes straight to allocation, a stored key is found by the
//   table scan and aged, a new key is allocated, and an unknown key with the
//   table full ends the request with no table write.
// Requests: one in flight at a time; the table scan compares one stored key per
//   cycle through the single registered RAM read port. A second
//   finished result holds the input until the first one is taken.
// Reset: table emptied, window_ticks set to 100000, no result pending.
// ----------------------------------------------------------------------------
module keyed_fixed_window_rate_limiter_top (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [kfwrl_pkg::KEY_W-1:0]   key_id,
  input  wire logic [kfwrl_pkg::LIMIT_W-1:0] limit,
  input  wire logic [kfwrl_pkg::TIME_W-1:0]  now,
  input  wire logic                          cfg_we,
  input  wire logic [kfwrl_pkg::TIME_W-1:0]  cfg_wdata,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic                               pass,
  output logic [1:0]                         outcome
);
  import kfwrl_pkg::*;

  logic [TIME_W-1:0] window_ticks;
  logic              ram_we;
  logic [IDX_W-1:0]  ram_waddr;
  logic [IDX_W-1:0]  ram_raddr;
  entry_t            ram_wdata;
  entry_t            ram_rdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_ticks <= WINDOW_RESET;
    end else if (cfg_we) begin
      window_ticks <= cfg_wdata;
    end
  end

  kfwrl_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TABLE_ENTRIES)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  kfwrl_seq u_seq (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .key_id       (key_id),
    .limit        (limit),
    .now          (now),
    .window_ticks (window_ticks),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .pass         (pass),
    .outcome      (outcome),
    .ram_we       (ram_we),
    .ram_waddr    (ram_waddr),
    .ram_wdata    (ram_wdata),
    .ram_raddr    (ram_raddr),
    .ram_rdata    (ram_rdata)
  );

  a_busy_after_transfer: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input taken while a request is in flight");

  a_pass_matches_outcome: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (pass == (outcome != OUT_SUPPRESS)))
    else $error("pass flag disagrees with outcome");

  a_result_from_busy: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> !$past(in_ready))
    else $error("result appeared without a request in flight");

endmodule
`default_nettype wire
